// ===== design/photon_arrival_time_calc_macros.svh =====
// Assertion macros for the photon arrival time block.
// Used by the checker that binds to the top level; needs nothing else.
`ifndef PHOTON_ARRIVAL_TIME_CALC_MACROS_SVH
`define PHOTON_ARRIVAL_TIME_CALC_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("photon arrival time check failed");

// Next-cycle implication, disabled while in reset.
`define PAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("photon arrival time check failed");

`endif

// ===== design/pat_pkg.sv =====
// Shared widths, reset values and codes for the photon arrival time block.
// No dependencies; every other file but the macro header imports it.
`default_nettype none

package pat_pkg;

  localparam int RADIUS_W         = 20;
  localparam int Z_W              = 21;
  localparam int SLOPE_W          = 32;
  localparam int TIME_W           = 24;
  localparam int ATIME_W          = 32;
  localparam int REGION_W         = 2;
  localparam int CFG_W            = 20;
  localparam int ILS_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int FRAC_W           = 16;
  localparam int LENGTH_WIDTH_DEF = 21;

  localparam int QUOT_W = RADIUS_W + 1 + FRAC_W;
  localparam int PROD_W = SLOPE_W + Z_W + 1;
  localparam int EXT_W  = QUOT_W + 2;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int RT_W   = ROOT_W + 2;
  localparam int FIN_W  = ATIME_W + 2;

  localparam logic [CFG_W-1:0] RST_BARREL_RADIUS       = 20'd12900;
  localparam logic [CFG_W-1:0] RST_BARREL_HALF_LENGTH  = 20'd30000;
  localparam logic [CFG_W-1:0] RST_ENDCAP_PLANE_Z      = 20'd31500;
  localparam logic [CFG_W-1:0] RST_ENDCAP_INNER_RADIUS = 20'd3160;
  localparam logic [CFG_W-1:0] RST_ENDCAP_OUTER_RADIUS = 20'd17100;
  localparam logic [ILS_W-1:0] RST_INVERSE_LIGHT_SPEED = 16'd21860;

  typedef enum logic [REGION_W-1:0] {
    REGION_BARREL = 2'd0,
    REGION_ENDCAP = 2'd1,
    REGION_MISSED = 2'd2
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BARREL_RADIUS       = 3'd0,
    CFG_BARREL_HALF_LENGTH  = 3'd1,
    CFG_ENDCAP_PLANE_Z      = 3'd2,
    CFG_ENDCAP_INNER_RADIUS = 3'd3,
    CFG_ENDCAP_OUTER_RADIUS = 3'd4,
    CFG_INVERSE_LIGHT_SPEED = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== design/pat_ifs.sv =====
// Valid/ready channel interfaces for decay beats in and arrival beats out.
// Depends on pat_pkg for field widths.
`default_nettype none

interface pat_in_if import pat_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [RADIUS_W-1:0]       decay_radius;
  logic signed [Z_W-1:0]     decay_z;
  logic signed [SLOPE_W-1:0] track_slope;
  logic [TIME_W-1:0]         decay_time;

  modport source (output valid, decay_radius, decay_z, track_slope, decay_time,
                  input ready);
  modport sink (input valid, decay_radius, decay_z, track_slope, decay_time,
                output ready);
endinterface

interface pat_out_if import pat_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ATIME_W-1:0] hit_time;
  logic [REGION_W-1:0]       region;

  modport source (output valid, hit_time, region, input ready);
  modport sink (input valid, hit_time, region, output ready);
endinterface

`default_nettype wire

// ===== design/photon_arrival_time_calc.sv =====
// Photon arrival time: projects a decay line to barrel or endcap, pipelined.
// Depends on pat_pkg and the channel interfaces in pat_ifs.sv.
//
//  channel | dir | beat payload
//  in_i    | in  | decay_radius, decay_z, track_slope, decay_time
//  out_o   | out | hit_time, region
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// One beat per cycle while input ready is high.
// The 37-step intercept divider and the 32-step square roots set the depth.
// Reset clears valid bits and loads register defaults; payload is not reset.
// An output register plus one skid entry decouple the sides; input ready
// drops only while the skid entry is full.
`default_nettype none

module photon_arrival_time_calc import pat_pkg::*; #(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  pat_in_if.sink               in_i,
  pat_out_if.source            out_o
);

  localparam int     W    = LENGTH_WIDTH;
  localparam int     DW   = ((W > Z_W) ? W : Z_W) + 1;
  localparam longint LMAX = (longint'(1) << (W - 1)) - 1;
  localparam longint LMIN = -LMAX - 1;
  localparam longint AMAX = (longint'(1) << (ATIME_W - 1)) - 1;
  localparam longint AMIN = -AMAX - 1;

  typedef struct packed {
    logic [RADIUS_W-1:0]   r0;
    logic signed [Z_W-1:0] z0;
    logic [TIME_W-1:0]     tau;
  } item_t;

  typedef struct packed {
    item_t               it;
    logic signed [W-1:0] re;
    logic                qneg;
    logic                szero;
    logic [SLOPE_W-1:0]  dvs;
  } div_side_t;

  typedef struct packed {
    logic [TIME_W-1:0] tau;
    region_e           region;
  } tail_t;

  function automatic logic signed [W-1:0] sat_len(input logic signed [EXT_W-1:0] v);
    logic signed [W-1:0] r;
    if (v > LMAX) begin
      r = W'(LMAX);
    end else if (v < LMIN) begin
      r = W'(LMIN);
    end else begin
      r = W'(v);
    end
    return r;
  endfunction

  // configuration registers
  logic [CFG_W-1:0] rb_q, bhl_q, ze_q, eir_q, eor_q;
  logic [ILS_W-1:0] ils_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q  <= RST_BARREL_RADIUS;
      bhl_q <= RST_BARREL_HALF_LENGTH;
      ze_q  <= RST_ENDCAP_PLANE_Z;
      eir_q <= RST_ENDCAP_INNER_RADIUS;
      eor_q <= RST_ENDCAP_OUTER_RADIUS;
      ils_q <= RST_INVERSE_LIGHT_SPEED;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BARREL_RADIUS:       rb_q  <= cfg_wdata_i;
        CFG_BARREL_HALF_LENGTH:  bhl_q <= cfg_wdata_i;
        CFG_ENDCAP_PLANE_Z:      ze_q  <= cfg_wdata_i;
        CFG_ENDCAP_INNER_RADIUS: eir_q <= cfg_wdata_i;
        CFG_ENDCAP_OUTER_RADIUS: eor_q <= cfg_wdata_i;
        CFG_INVERSE_LIGHT_SPEED: ils_q <= cfg_wdata_i[ILS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;

  assign en       = !skid_v_q;
  assign in_i.ready = en;

  // stage 1: operand prep and endcap product
  logic signed [RADIUS_W:0]  num;
  logic [RADIUS_W:0]         num_mag;
  logic signed [Z_W:0]       dz;
  logic signed [PROD_W-1:0]  prod;
  logic [SLOPE_W-1:0]        smag;

  assign num     = $signed({1'b0, rb_q}) - $signed({1'b0, in_i.decay_radius});
  assign num_mag = num[RADIUS_W] ? -num : num;
  assign dz      = $signed({2'b00, ze_q}) - {in_i.decay_z[Z_W-1], in_i.decay_z};
  assign prod    = in_i.track_slope * dz;
  assign smag    = in_i.track_slope[SLOPE_W-1] ? -in_i.track_slope : in_i.track_slope;

  logic                     s1_v_q;
  item_t                    s1_it_q;
  logic signed [PROD_W-1:0] s1_prod_q;
  logic [QUOT_W-1:0]        s1_dvd_q;
  logic [SLOPE_W-1:0]       s1_dvs_q;
  logic                     s1_qneg_q, s1_szero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q     <= in_i.valid;
      s1_it_q    <= '{r0: in_i.decay_radius, z0: in_i.decay_z, tau: in_i.decay_time};
      s1_prod_q  <= prod;
      s1_dvd_q   <= {num_mag, {FRAC_W{1'b0}}};
      s1_dvs_q   <= smag;
      s1_qneg_q  <= num[RADIUS_W] ^ in_i.track_slope[SLOPE_W-1];
      s1_szero_q <= (in_i.track_slope == '0);
    end
  end

  // endcap radius, truncated toward zero and saturated
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [EXT_W-1:0]  re_raw;

  assign prod_adj = s1_prod_q +
                    $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{s1_prod_q[PROD_W-1]}}});
  assign re_raw   = $signed({{(EXT_W-RADIUS_W){1'b0}}, s1_it_q.r0}) +
                    EXT_W'($signed(prod_adj[PROD_W-1:FRAC_W]));

  // barrel intercept divider, one quotient bit per stage
  logic              d_v    [0:QUOT_W];
  div_side_t         d_side [0:QUOT_W];
  logic [SLOPE_W-1:0] d_rem [0:QUOT_W];
  logic [QUOT_W-1:0] d_dq   [0:QUOT_W];

  assign d_v[0]    = s1_v_q;
  assign d_rem[0]  = '0;
  assign d_dq[0]   = s1_dvd_q;
  assign d_side[0] = '{it: s1_it_q, re: sat_len(re_raw), qneg: s1_qneg_q,
                       szero: s1_szero_q, dvs: s1_dvs_q};

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    logic               v_q;
    div_side_t          side_q;
    logic [SLOPE_W-1:0] rem_q;
    logic [QUOT_W-1:0]  dq_q;
    logic [SLOPE_W:0]   rem_sh, rem_sub;
    logic               ge;

    assign rem_sh  = {d_rem[k], d_dq[k][QUOT_W-1]};
    assign ge      = rem_sh >= {1'b0, d_side[k].dvs};
    assign rem_sub = rem_sh - {1'b0, d_side[k].dvs};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q    <= d_v[k];
        side_q <= d_side[k];
        rem_q  <= ge ? rem_sub[SLOPE_W-1:0] : rem_sh[SLOPE_W-1:0];
        dq_q   <= {d_dq[k][QUOT_W-2:0], ge};
      end
    end

    assign d_v[k+1]    = v_q;
    assign d_side[k+1] = side_q;
    assign d_rem[k+1]  = rem_q;
    assign d_dq[k+1]   = dq_q;
  end

  // stage 3: signed intercept
  logic signed [QUOT_W:0]  zq;
  logic signed [EXT_W-1:0] zb_raw;
  logic signed [W-1:0]     zb;

  assign zq     = d_side[QUOT_W].qneg ? -$signed({1'b0, d_dq[QUOT_W]})
                                      : $signed({1'b0, d_dq[QUOT_W]});
  assign zb_raw = EXT_W'(zq) + EXT_W'($signed(d_side[QUOT_W].it.z0));
  assign zb     = d_side[QUOT_W].szero ? W'(LMAX) : sat_len(zb_raw);

  logic                s3_v_q;
  item_t               s3_it_q;
  logic signed [W-1:0] s3_re_q, s3_zb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q  <= d_v[QUOT_W];
      s3_it_q <= d_side[QUOT_W].it;
      s3_re_q <= d_side[QUOT_W].re;
      s3_zb_q <= zb;
    end
  end

  // stage 4: region and path operands
  logic signed [DW-1:0] rb_x, ze_x, bhl_x, eir_x, eor_x, r0_x, z0_x, zb_x, re_x, zb_mag;
  logic                 in_barrel, in_ring;
  region_e              region;
  logic signed [DW-1:0] op [4];

  assign rb_x   = $signed({{(DW-CFG_W){1'b0}}, rb_q});
  assign ze_x   = $signed({{(DW-CFG_W){1'b0}}, ze_q});
  assign bhl_x  = $signed({{(DW-CFG_W){1'b0}}, bhl_q});
  assign eir_x  = $signed({{(DW-CFG_W){1'b0}}, eir_q});
  assign eor_x  = $signed({{(DW-CFG_W){1'b0}}, eor_q});
  assign r0_x   = $signed({{(DW-RADIUS_W){1'b0}}, s3_it_q.r0});
  assign z0_x   = DW'($signed(s3_it_q.z0));
  assign zb_x   = DW'(s3_zb_q);
  assign re_x   = DW'(s3_re_q);
  assign zb_mag = zb_x[DW-1] ? -zb_x : zb_x;

  assign in_barrel = zb_mag < bhl_x;
  assign in_ring   = (re_x > eir_x) && (re_x < eor_x);

  always_comb begin
    priority if (in_barrel) begin
      region = REGION_BARREL;
      op[0]  = rb_x - r0_x;
      op[1]  = zb_x - z0_x;
      op[2]  = rb_x;
      op[3]  = zb_x;
    end else if (in_ring) begin
      region = REGION_ENDCAP;
      op[0]  = re_x - r0_x;
      op[1]  = ze_x - z0_x;
      op[2]  = r0_x;
      op[3]  = ze_x;
    end else begin
      region = REGION_MISSED;
      op[0]  = '0;
      op[1]  = '0;
      op[2]  = '0;
      op[3]  = '0;
    end
  end

  logic                 s4_v_q;
  tail_t                s4_tl_q;
  logic signed [DW-1:0] s4_op_q [4];
  logic                 s5_v_q;
  tail_t                s5_tl_q;
  logic [DW-1:0]        s5_mag_q [4];
  logic                 s6_v_q;
  tail_t                s6_tl_q;
  logic [SUM_W-1:0]     s6_sq_q [4];
  logic                 s7_v_q;
  tail_t                s7_tl_q;
  logic [SUM_W-1:0]     s7_sum_q [2];
  logic [2*DW-1:0]      sq_full [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_full[i] = s5_mag_q[i] * s5_mag_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q  <= s3_v_q;
      s4_tl_q <= '{tau: s3_it_q.tau, region: region};
      s5_v_q  <= s4_v_q;
      s5_tl_q <= s4_tl_q;
      s6_v_q  <= s5_v_q;
      s6_tl_q <= s5_tl_q;
      s7_v_q  <= s6_v_q;
      s7_tl_q <= s6_tl_q;
      for (int i = 0; i < 4; i++) begin
        s4_op_q[i]  <= op[i];
        s5_mag_q[i] <= s4_op_q[i][DW-1] ? -s4_op_q[i] : s4_op_q[i];
        s6_sq_q[i]  <= SUM_W'(sq_full[i]);
      end
      s7_sum_q[0] <= s6_sq_q[0] + s6_sq_q[1];
      s7_sum_q[1] <= s6_sq_q[2] + s6_sq_q[3];
    end
  end

  // floor square roots, two lanes, one root bit per stage
  logic                        q_v    [0:ROOT_W];
  tail_t                       q_tl   [0:ROOT_W];
  logic [1:0][RT_W-1:0]        q_rem  [0:ROOT_W];
  logic [1:0][ROOT_W-1:0]      q_root [0:ROOT_W];
  logic [1:0][SUM_W-1:0]       q_rad  [0:ROOT_W];

  assign q_v[0]    = s7_v_q;
  assign q_tl[0]   = s7_tl_q;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_rad[0]  = {s7_sum_q[1], s7_sum_q[0]};

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic                   v_q;
    tail_t                  tl_q;
    logic [1:0][RT_W-1:0]   rem_q, rem_d;
    logic [1:0][ROOT_W-1:0] root_q, root_d;
    logic [1:0][SUM_W-1:0]  rad_q, rad_d;
    logic [RT_W+1:0]        rsh   [2];
    logic [RT_W+1:0]        trial [2];
    logic [1:0]             ge;

    always_comb begin
      for (int j = 0; j < 2; j++) begin
        rsh[j]    = {q_rem[k][j], q_rad[k][j][SUM_W-1 -: 2]};
        trial[j]  = {2'b00, q_root[k][j], 2'b01};
        ge[j]     = rsh[j] >= trial[j];
        rem_d[j]  = ge[j] ? RT_W'(rsh[j] - trial[j]) : RT_W'(rsh[j]);
        root_d[j] = {q_root[k][j][ROOT_W-2:0], ge[j]};
        rad_d[j]  = {q_rad[k][j][SUM_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q    <= q_v[k];
        tl_q   <= q_tl[k];
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= rad_d;
      end
    end

    assign q_v[k+1]    = v_q;
    assign q_tl[k+1]   = tl_q;
    assign q_rem[k+1]  = rem_q;
    assign q_root[k+1] = root_q;
    assign q_rad[k+1]  = rad_q;
  end

  // length to picoseconds, then combine and saturate
  logic [ROOT_W+ILS_W-1:0] tprod [2];

  assign tprod[0] = q_root[ROOT_W][0] * ils_q;
  assign tprod[1] = q_root[ROOT_W][1] * ils_q;

  logic                       st_v_q;
  tail_t                      st_tl_q;
  logic [ROOT_W+ILS_W-FRAC_W-1:0] st_t_q [2];

  logic signed [FIN_W-1:0]   fin;
  logic signed [ATIME_W-1:0] fin_sat;

  assign fin = $signed({{(FIN_W-TIME_W){1'b0}}, st_tl_q.tau}) +
               $signed({2'b00, st_t_q[0]}) - $signed({2'b00, st_t_q[1]});

  always_comb begin
    priority if (st_tl_q.region == REGION_MISSED) begin
      fin_sat = '0;
    end else if (fin > AMAX) begin
      fin_sat = ATIME_W'(AMAX);
    end else if (fin < AMIN) begin
      fin_sat = ATIME_W'(AMIN);
    end else begin
      fin_sat = ATIME_W'(fin);
    end
  end

  logic                      f_v_q;
  logic signed [ATIME_W-1:0] f_time_q;
  region_e                   f_region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
      f_v_q  <= 1'b0;
    end else if (en) begin
      st_v_q     <= q_v[ROOT_W];
      st_tl_q    <= q_tl[ROOT_W];
      st_t_q[0]  <= tprod[0][ROOT_W+ILS_W-1:FRAC_W];
      st_t_q[1]  <= tprod[1][ROOT_W+ILS_W-1:FRAC_W];
      f_v_q      <= st_v_q;
      f_time_q   <= fin_sat;
      f_region_q <= st_tl_q.region;
    end
  end

  // output register and skid entry
  logic                      out_v_q;
  logic signed [ATIME_W-1:0] out_time_q, skid_time_q;
  region_e                   out_region_q, skid_region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_o.ready) begin
        out_v_q      <= 1'b1;
        out_time_q   <= skid_time_q;
        out_region_q <= skid_region_q;
        skid_v_q     <= 1'b0;
      end
    end else if (f_v_q) begin
      if (!out_v_q || out_o.ready) begin
        out_v_q      <= 1'b1;
        out_time_q   <= f_time_q;
        out_region_q <= f_region_q;
      end else begin
        skid_v_q      <= 1'b1;
        skid_time_q   <= f_time_q;
        skid_region_q <= f_region_q;
      end
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.hit_time = out_time_q;
  assign out_o.region   = out_region_q;

endmodule

`default_nettype wire

// ===== design/pat_checker.sv =====
// Port-level checks on the photon arrival time block, bound to the top level.
// Depends on pat_pkg and photon_arrival_time_calc_macros.svh.
`default_nettype none
`include "photon_arrival_time_calc_macros.svh"

module pat_checker import pat_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [ATIME_W-1:0] out_time_i,
  input logic [REGION_W-1:0]       out_region_i
);

  `PAT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PAT_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_time_i) && $stable(out_region_i))
  `PAT_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_i && (out_region_i == REGION_MISSED), out_time_i == '0)
  `PAT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_i, $past(out_valid_i && !out_ready_i))
  `PAT_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind photon_arrival_time_calc pat_checker u_pat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_time_i   (out_o.hit_time),
  .out_region_i (out_o.region)
);

`default_nettype wire
